/* hdl/sprel_pkg.sv */
// shared types, widths and helpers for the segment pair relation block
`timescale 1ns / 1ps

package sprel_pkg;

    // coordinate and derived arithmetic widths
    localparam int COORD_WIDTH = 16;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int CROSS_W     = PROD_W + 1;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]      t_diff;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [CROSS_W-1:0]     t_cross;

    // relation codes
    typedef enum logic [2:0] {
        REL_DISJOINT  = 3'd0,
        REL_CROSS_MID = 3'd1,
        REL_END_MID   = 3'd2,
        REL_END_END   = 3'd3,
        REL_OVERLAP   = 3'd4
    } t_relation;

    // exact difference of two coordinates
    function automatic t_diff coord_sub(input t_coord a, input t_coord b);
        t_diff ea;
        t_diff eb;
        ea = t_diff'(a);
        eb = t_diff'(b);
        return ea - eb;
    endfunction

    // magnitude of a difference
    function automatic logic [DIFF_W-1:0] diff_abs(input t_diff d);
        t_diff neg;
        neg = -d;
        return d[DIFF_W-1] ? $unsigned(neg) : $unsigned(d);
    endfunction

    // signed minimum and maximum of two coordinates
    function automatic t_coord coord_min(input t_coord a, input t_coord b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_coord coord_max(input t_coord a, input t_coord b);
        return (a > b) ? a : b;
    endfunction

endpackage

/* hdl/segment_pair_relation.sv */
// segment pair relation: three stage pipeline from endpoints to relation code
// a taken transaction passes the valid registers r_v1, r_v2 and r_v3 in turn; o_done is r_v3
// throughput: one transaction per cycle, busy is never raised; the receiver cannot stall
// stage 1 registers endpoints, stage 2 the eight cross product terms and interval bounds,
// stage 3 the relation code, so the multiplier array sets the clock
// reset (synchronous, active low) clears the valid pipeline; payload registers are not reset
`timescale 1ns / 1ps

module segment_pair_relation (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  sprel_pkg::t_coord       i_a_start_x,
    input  sprel_pkg::t_coord       i_a_start_y,
    input  sprel_pkg::t_coord       i_a_end_x,
    input  sprel_pkg::t_coord       i_a_end_y,
    input  sprel_pkg::t_coord       i_b_start_x,
    input  sprel_pkg::t_coord       i_b_start_y,
    input  sprel_pkg::t_coord       i_b_end_x,
    input  sprel_pkg::t_coord       i_b_end_y,
    output logic                    o_done,
    output logic [2:0]              o_relation
);
    import sprel_pkg::*;

    // stage 1: captured endpoints
    logic   r_v1;
    t_coord r_a1x, r_a1y, r_a2x, r_a2y, r_b1x, r_b1y, r_b2x, r_b2y;

    // stage 2: cross product terms and interval bounds
    logic   r_v2;
    t_prod  r_p [8];
    logic   r_use_x;
    t_coord r_amin_x, r_amax_x, r_bmin_x, r_bmax_x;
    t_coord r_amin_y, r_amax_y, r_bmin_y, r_bmax_y;

    // stage 3: result
    logic      r_v3;
    t_relation r_rel;
    t_relation n_rel;

    // stage 2 next values
    t_diff  n_bdx, n_bdy, n_adx, n_ady;
    t_diff  n_a1bx, n_a1by, n_a2bx, n_a2by;
    t_diff  n_b1ax, n_b1ay, n_b2ax, n_b2ay;
    logic   n_a_point;
    logic   n_use_x;

    // stage 3 combinational signals
    t_cross c_sa1, c_sa2, c_sb1, c_sb2;
    logic   sa1_pos, sa1_neg, sa2_pos, sa2_neg;
    logic   sb1_pos, sb1_neg, sb2_pos, sb2_neg;
    logic   pa_pos, pa_neg, pa_zero, pb_pos, pb_neg, pb_zero;
    logic   any_side;
    t_coord sel_amin, sel_amax, sel_bmin, sel_bmax, lo, hi;

    // every cycle can take a transaction
    assign busy = 1'b0;

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // stage 1 endpoint capture
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_a1x <= i_a_start_x;
            r_a1y <= i_a_start_y;
            r_a2x <= i_a_end_x;
            r_a2y <= i_a_end_y;
            r_b1x <= i_b_start_x;
            r_b1y <= i_b_start_y;
            r_b2x <= i_b_end_x;
            r_b2y <= i_b_end_y;
        end
    end

    // differences for the four cross products and the axis choice
    always_comb begin
        n_bdx  = coord_sub(r_b2x, r_b1x);
        n_bdy  = coord_sub(r_b2y, r_b1y);
        n_adx  = coord_sub(r_a2x, r_a1x);
        n_ady  = coord_sub(r_a2y, r_a1y);
        n_a1bx = coord_sub(r_a1x, r_b1x);
        n_a1by = coord_sub(r_a1y, r_b1y);
        n_a2bx = coord_sub(r_a2x, r_b1x);
        n_a2by = coord_sub(r_a2y, r_b1y);
        n_b1ax = coord_sub(r_b1x, r_a1x);
        n_b1ay = coord_sub(r_b1y, r_a1y);
        n_b2ax = coord_sub(r_b2x, r_a1x);
        n_b2ay = coord_sub(r_b2y, r_a1y);
        n_a_point = (r_a1x == r_a2x) && (r_a1y == r_a2y);
        n_use_x = n_a_point ? (diff_abs(n_bdx) > diff_abs(n_bdy))
                            : (diff_abs(n_adx) > diff_abs(n_ady));
    end

    // stage 2 products and interval bounds
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_p[0]   <= n_bdx * n_a1by;
            r_p[1]   <= n_a1bx * n_bdy;
            r_p[2]   <= n_bdx * n_a2by;
            r_p[3]   <= n_a2bx * n_bdy;
            r_p[4]   <= n_adx * n_b1ay;
            r_p[5]   <= n_b1ax * n_ady;
            r_p[6]   <= n_adx * n_b2ay;
            r_p[7]   <= n_b2ax * n_ady;
            r_use_x  <= n_use_x;
            r_amin_x <= coord_min(r_a1x, r_a2x);
            r_amax_x <= coord_max(r_a1x, r_a2x);
            r_bmin_x <= coord_min(r_b1x, r_b2x);
            r_bmax_x <= coord_max(r_b1x, r_b2x);
            r_amin_y <= coord_min(r_a1y, r_a2y);
            r_amax_y <= coord_max(r_a1y, r_a2y);
            r_bmin_y <= coord_min(r_b1y, r_b2y);
            r_bmax_y <= coord_max(r_b1y, r_b2y);
        end
    end

    // cross product signs
    always_comb begin
        c_sa1 = t_cross'(r_p[0]) - t_cross'(r_p[1]);
        c_sa2 = t_cross'(r_p[2]) - t_cross'(r_p[3]);
        c_sb1 = t_cross'(r_p[4]) - t_cross'(r_p[5]);
        c_sb2 = t_cross'(r_p[6]) - t_cross'(r_p[7]);
        sa1_neg = c_sa1[CROSS_W-1];
        sa2_neg = c_sa2[CROSS_W-1];
        sb1_neg = c_sb1[CROSS_W-1];
        sb2_neg = c_sb2[CROSS_W-1];
        sa1_pos = !sa1_neg && (c_sa1 != '0);
        sa2_pos = !sa2_neg && (c_sa2 != '0);
        sb1_pos = !sb1_neg && (c_sb1 != '0);
        sb2_pos = !sb2_neg && (c_sb2 != '0);
        pa_pos  = (sa1_pos && sa2_pos) || (sa1_neg && sa2_neg);
        pa_neg  = (sa1_pos && sa2_neg) || (sa1_neg && sa2_pos);
        pa_zero = !pa_pos && !pa_neg;
        pb_pos  = (sb1_pos && sb2_pos) || (sb1_neg && sb2_neg);
        pb_neg  = (sb1_pos && sb2_neg) || (sb1_neg && sb2_pos);
        pb_zero = !pb_pos && !pb_neg;
        any_side = sa1_pos || sa1_neg || sa2_pos || sa2_neg
                || sb1_pos || sb1_neg || sb2_pos || sb2_neg;
    end

    // collinear interval overlap on the chosen axis
    always_comb begin
        sel_amin = r_use_x ? r_amin_x : r_amin_y;
        sel_amax = r_use_x ? r_amax_x : r_amax_y;
        sel_bmin = r_use_x ? r_bmin_x : r_bmin_y;
        sel_bmax = r_use_x ? r_bmax_x : r_bmax_y;
        lo = coord_max(sel_amin, sel_bmin);
        hi = coord_min(sel_amax, sel_bmax);
    end

    // relation decision
    always_comb begin
        priority if (pa_pos || pb_pos) begin
            n_rel = REL_DISJOINT;
        end else if (pa_neg && pb_neg) begin
            n_rel = REL_CROSS_MID;
        end else if (pa_zero && pb_zero && any_side) begin
            n_rel = REL_END_END;
        end else if (pa_zero && pb_zero) begin
            if (lo < hi) begin
                n_rel = REL_OVERLAP;
            end else if (lo > hi) begin
                n_rel = REL_DISJOINT;
            end else begin
                n_rel = REL_END_END;
            end
        end else begin
            n_rel = REL_END_MID;
        end
    end

    // stage 3 result register
    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_rel <= n_rel;
        end
    end

    assign o_done     = r_v3;
    assign o_relation = r_rel;

    // a result strobe follows each transaction
    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##2 o_done)
        else $error("missing result strobe");

    // no result strobe without an earlier transaction
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, 3))
        else $error("result strobe without transaction");

    // a delivered code is always a defined relation
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_relation == REL_DISJOINT || o_relation == REL_CROSS_MID
                 || o_relation == REL_END_MID || o_relation == REL_END_END
                 || o_relation == REL_OVERLAP))
        else $error("undefined relation code");

endmodule

/* dv/segment_pair_relation_tb.sv */
// testbench for segment_pair_relation: queued driver, clocked monitor, built-in predictor
`timescale 1ns / 1ps

module segment_pair_relation_tb;

    import sprel_pkg::*;

    // one transaction: both segments, one port per coordinate
    typedef struct {
        t_coord a_start_x;
        t_coord a_start_y;
        t_coord a_end_x;
        t_coord a_end_y;
        t_coord b_start_x;
        t_coord b_start_y;
        t_coord b_end_x;
        t_coord b_end_y;
    } t_seg_pair;

    localparam int RANDOM_PER_PHASE = 225;
    localparam int NUM_PHASES       = 4;
    localparam int DRAIN_CYCLES     = 8;

    logic       i_clk;
    logic       i_rst_n   = 1'b0;
    logic       start     = 1'b0;
    logic       busy;
    t_coord     a_start_x = '0;
    t_coord     a_start_y = '0;
    t_coord     a_end_x   = '0;
    t_coord     a_end_y   = '0;
    t_coord     b_start_x = '0;
    t_coord     b_start_y = '0;
    t_coord     b_end_x   = '0;
    t_coord     b_end_y   = '0;
    logic       o_done;
    logic [2:0] o_relation;

    t_seg_pair  pending_pairs[$];
    t_relation  relation_queue[$];
    t_seg_pair  in_flight;
    t_relation  want_relation;
    int         idle_pct       = 0;
    int         mismatch_count = 0;

    segment_pair_relation dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_a_start_x (a_start_x),
        .i_a_start_y (a_start_y),
        .i_a_end_x   (a_end_x),
        .i_a_end_y   (a_end_y),
        .i_b_start_x (b_start_x),
        .i_b_start_y (b_start_y),
        .i_b_end_x   (b_end_x),
        .i_b_end_y   (b_end_y),
        .o_done      (o_done),
        .o_relation  (o_relation)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // orientation of r against the directed line o -> q: -1, 0 or +1
    function automatic int orientation(input longint ox, input longint oy,
                                       input longint qx, input longint qy,
                                       input longint rx, input longint ry);
        longint c;
        c = (qx - ox) * (ry - oy) - (rx - ox) * (qy - oy);
        if (c > 0)
            return 1;
        else if (c < 0)
            return -1;
        return 0;
    endfunction

    // relation of the two segments, exact integer arithmetic
    function automatic t_relation predict_relation(input t_seg_pair p);
        longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        longint span_x, span_y, amin, amax, bmin, bmax, lo, hi;
        int     sa0, sa1, sb0, sb1, prod_a, prod_b;
        ax0 = p.a_start_x; ay0 = p.a_start_y; ax1 = p.a_end_x; ay1 = p.a_end_y;
        bx0 = p.b_start_x; by0 = p.b_start_y; bx1 = p.b_end_x; by1 = p.b_end_y;
        sa0 = orientation(bx0, by0, bx1, by1, ax0, ay0);
        sa1 = orientation(bx0, by0, bx1, by1, ax1, ay1);
        sb0 = orientation(ax0, ay0, ax1, ay1, bx0, by0);
        sb1 = orientation(ax0, ay0, ax1, ay1, bx1, by1);
        prod_a = sa0 * sa1;
        prod_b = sb0 * sb1;
        if (prod_a > 0 || prod_b > 0)
            return REL_DISJOINT;
        if (prod_a < 0 && prod_b < 0)
            return REL_CROSS_MID;
        if (prod_a != 0 || prod_b != 0)
            return REL_END_MID;
        if (sa0 != 0 || sa1 != 0 || sb0 != 0 || sb1 != 0)
            return REL_END_END;
        // all collinear: axis of greater spread, taken from b when a is a point
        if (ax0 == ax1 && ay0 == ay1) begin
            span_x = bx1 - bx0;
            span_y = by1 - by0;
        end else begin
            span_x = ax1 - ax0;
            span_y = ay1 - ay0;
        end
        if (span_x < 0) span_x = -span_x;
        if (span_y < 0) span_y = -span_y;
        if (span_x > span_y) begin
            amin = (ax0 < ax1) ? ax0 : ax1; amax = (ax0 > ax1) ? ax0 : ax1;
            bmin = (bx0 < bx1) ? bx0 : bx1; bmax = (bx0 > bx1) ? bx0 : bx1;
        end else begin
            amin = (ay0 < ay1) ? ay0 : ay1; amax = (ay0 > ay1) ? ay0 : ay1;
            bmin = (by0 < by1) ? by0 : by1; bmax = (by0 > by1) ? by0 : by1;
        end
        lo = (amin > bmin) ? amin : bmin;
        hi = (amax < bmax) ? amax : bmax;
        if (lo < hi)
            return REL_OVERLAP;
        if (lo > hi)
            return REL_DISJOINT;
        return REL_END_END;
    endfunction

    function automatic t_seg_pair mk_pair(input int ax0, input int ay0, input int ax1,
                                          input int ay1, input int bx0, input int by0,
                                          input int bx1, input int by1);
        t_seg_pair p;
        p.a_start_x = t_coord'(ax0); p.a_start_y = t_coord'(ay0);
        p.a_end_x   = t_coord'(ax1); p.a_end_y   = t_coord'(ay1);
        p.b_start_x = t_coord'(bx0); p.b_start_y = t_coord'(by0);
        p.b_end_x   = t_coord'(bx1); p.b_end_y   = t_coord'(by1);
        return p;
    endfunction

    function automatic int rand_int(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // random pair, many built around a shared line so every relation shows up
    function automatic t_seg_pair random_pair();
        int pick, px, py, dx, dy, k, j;
        int a0x, a0y, a1x, a1y, b0x, b0y, b1x, b1y;
        pick = $urandom_range(99);
        px = rand_int(-16000, 16000);
        py = rand_int(-16000, 16000);
        dx = rand_int(-40, 40);
        dy = rand_int(-40, 40);
        k  = rand_int(2, 150);
        j  = rand_int(1, k - 1);
        if (pick < 12) begin
            // full range noise
            a0x = rand_int(-32768, 32767); a0y = rand_int(-32768, 32767);
            a1x = rand_int(-32768, 32767); a1y = rand_int(-32768, 32767);
            b0x = rand_int(-32768, 32767); b0y = rand_int(-32768, 32767);
            b1x = rand_int(-32768, 32767); b1y = rand_int(-32768, 32767);
        end else if (pick < 27) begin
            // tiny box, lots of collinear and touching cases
            a0x = rand_int(-6, 6); a0y = rand_int(-6, 6);
            a1x = rand_int(-6, 6); a1y = rand_int(-6, 6);
            b0x = rand_int(-6, 6); b0y = rand_int(-6, 6);
            b1x = rand_int(-6, 6); b1y = rand_int(-6, 6);
        end else if (pick < 42) begin
            // four points on one line
            k = rand_int(-150, 150); a0x = px + k * dx; a0y = py + k * dy;
            k = rand_int(-150, 150); a1x = px + k * dx; a1y = py + k * dy;
            k = rand_int(-150, 150); b0x = px + k * dx; b0y = py + k * dy;
            k = rand_int(-150, 150); b1x = px + k * dx; b1y = py + k * dy;
        end else if (pick < 57) begin
            // endpoint of b inside a
            a0x = px;          a0y = py;
            a1x = px + k * dx; a1y = py + k * dy;
            b0x = px + j * dx; b0y = py + j * dy;
            b1x = b0x + rand_int(-300, 300); b1y = b0y + rand_int(-300, 300);
        end else if (pick < 70) begin
            // shared endpoint
            a0x = px + rand_int(-300, 300); a0y = py + rand_int(-300, 300);
            a1x = px;                       a1y = py;
            b0x = px;                       b0y = py;
            b1x = px + rand_int(-300, 300); b1y = py + rand_int(-300, 300);
        end else if (pick < 80) begin
            // a is a point near or on b's line
            j = rand_int(-20, 170);
            a0x = px + j * dx; a0y = py + j * dy;
            if ($urandom_range(3) == 0)
                a0y = a0y + rand_int(-2, 2);
            a1x = a0x;         a1y = a0y;
            b0x = px;          b0y = py;
            b1x = px + k * dx; b1y = py + k * dy;
        end else begin
            // general position around a point, crossing or not
            a0x = px + rand_int(-300, 300); a0y = py + rand_int(-300, 300);
            a1x = px + rand_int(-300, 300); a1y = py + rand_int(-300, 300);
            b0x = px + rand_int(-300, 300); b0y = py + rand_int(-300, 300);
            b1x = px + rand_int(-300, 300); b1y = py + rand_int(-300, 300);
        end
        // random roles and endpoint order
        if ($urandom_range(1))
            return mk_pair(b1x, b1y, b0x, b0y, a0x, a0y, a1x, a1y);
        return mk_pair(a0x, a0y, a1x, a1y, b0x, b0y, b1x, b1y);
    endfunction

    // driver: takes the next pair from the queue, records its expected relation on accept
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                relation_queue.push_back(predict_relation(in_flight));
            if (!start || !busy) begin
                if (pending_pairs.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    in_flight = pending_pairs.pop_front();
                    start     <= 1'b1;
                    a_start_x <= in_flight.a_start_x;
                    a_start_y <= in_flight.a_start_y;
                    a_end_x   <= in_flight.a_end_x;
                    a_end_y   <= in_flight.a_end_y;
                    b_start_x <= in_flight.b_start_x;
                    b_start_y <= in_flight.b_start_y;
                    b_end_x   <= in_flight.b_end_x;
                    b_end_y   <= in_flight.b_end_y;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each strobed relation with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            if (relation_queue.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, actual relation %0d",
                         $time, o_relation);
                mismatch_count++;
            end else begin
                want_relation = relation_queue.pop_front();
                if (o_relation !== want_relation) begin
                    $display("%0t: relation mismatch, expected %0d, actual %0d",
                             $time, want_relation, o_relation);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus: reset, directed pairs, then random phases with idle rates of 0, 58 or 9 percent
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            @(negedge i_clk);
            idle_pct = (ph == 1) ? 58 : (ph == 3) ? 9 : 0;
            if (ph == 0) begin
                // interior cross, parallel apart, one-sided miss
                pending_pairs.push_back(mk_pair(-10, 0, 10, 0, 0, -10, 0, 10));
                pending_pairs.push_back(mk_pair(0, 0, 10, 0, 0, 5, 10, 5));
                pending_pairs.push_back(mk_pair(0, 0, 10, 0, 20, -5, 20, 5));
                // endpoint of one in the middle of the other, both ways
                pending_pairs.push_back(mk_pair(0, 0, 10, 0, 5, 0, 5, 8));
                pending_pairs.push_back(mk_pair(5, 0, 5, 8, 0, 0, 10, 0));
                pending_pairs.push_back(mk_pair(0, 0, 10, 0, 10, -5, 10, 5));
                // shared endpoint
                pending_pairs.push_back(mk_pair(0, 0, 10, 0, 10, 0, 10, 10));
                pending_pairs.push_back(mk_pair(0, 0, 10, 0, 0, 0, -5, 5));
                // collinear: overlap, gap, touching, vertical, diagonal tie
                pending_pairs.push_back(mk_pair(0, 0, 10, 0, 5, 0, 15, 0));
                pending_pairs.push_back(mk_pair(0, 0, 10, 0, 12, 0, 20, 0));
                pending_pairs.push_back(mk_pair(0, 0, 10, 0, 10, 0, 20, 0));
                pending_pairs.push_back(mk_pair(3, -5, 3, 5, 3, 0, 3, 9));
                pending_pairs.push_back(mk_pair(0, 0, 4, 4, 2, 2, 6, 6));
                pending_pairs.push_back(mk_pair(1, 2, 9, 6, 9, 6, 1, 2));
                // line extension only
                pending_pairs.push_back(mk_pair(0, 0, 10, 0, 15, 0, 15, 5));
                // point-like segments
                pending_pairs.push_back(mk_pair(5, 0, 5, 0, 0, 0, 10, 0));
                pending_pairs.push_back(mk_pair(5, 3, 5, 3, 0, 0, 10, 0));
                pending_pairs.push_back(mk_pair(20, 0, 20, 0, 0, 0, 10, 0));
                pending_pairs.push_back(mk_pair(0, 0, 10, 0, 5, 0, 5, 0));
                pending_pairs.push_back(mk_pair(7, 7, 7, 7, 7, 7, 7, 7));
                pending_pairs.push_back(mk_pair(4, 0, 4, 0, 4, -3, 4, 9));
                // coordinate extremes
                pending_pairs.push_back(mk_pair(-32768, -32768, 32767, 32767,
                                                -32768, 32767, 32767, -32768));
                pending_pairs.push_back(mk_pair(-32768, 0, 32767, 0, 0, 0, 32767, 0));
                pending_pairs.push_back(mk_pair(32767, -32768, 32767, 32767,
                                                -32768, -32768, 32767, 0));
                pending_pairs.push_back(mk_pair(32767, 32767, -32768, -32768,
                                                32767, 32767, -32768, 32767));
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                pending_pairs.push_back(random_pair());
            // hold off until every expected relation has come back
            while (pending_pairs.size() != 0 || start || relation_queue.size() != 0)
                @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && relation_queue.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
